// File: rtl/der_unpk_pkg.sv
// ----------------------------------------------------------------------------
// DER signature unpacker package
// Status codes and the result record shared by the parser and the top level.
// ----------------------------------------------------------------------------
package der_unpk_pkg;

	localparam logic [7:0] SEQ_TAG = 8'h30;
	localparam logic [7:0] INT_TAG = 8'h02;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_SEQTAG = 3'd1,
		ST_LEN    = 3'd2,
		ST_INTTAG = 3'd3,
		ST_OVER   = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       done_res;
		status_t    status;
		logic [7:0] raw_length;
	} res_t;

endpackage

// File: rtl/der_unpk_if.sv
// ----------------------------------------------------------------------------
// DER signature unpacker channels
// Valid/ready channels for signature bytes in and raw r/s results out.
// ----------------------------------------------------------------------------
interface der_unpk_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_req;
	logic [7:0] total_length;

	modport source (output valid, data_byte, start_req, total_length, input ready);
	modport sink   (input valid, data_byte, start_req, total_length, output ready);
endinterface

interface der_unpk_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       done_res;
	logic [2:0] status;
	logic [7:0] raw_length;

	modport source (output valid, out_byte, byte_valid, done_res, status, raw_length,
		input ready);
	modport sink   (input valid, out_byte, byte_valid, done_res, status, raw_length,
		output ready);
endinterface

// File: rtl/der_unpk_parser.sv
// ----------------------------------------------------------------------------
// DER signature parser
// Holds the parse state and works out the result of one accepted beat.
// ----------------------------------------------------------------------------
module der_unpk_parser #(
	parameter int MAX_RAW_BYTES = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic [7:0]         data_byte,
	input  logic               start_req,
	input  logic [7:0]         total_length,
	output logic               res_valid,
	output der_unpk_pkg::res_t res
);
	import der_unpk_pkg::*;

	localparam int CNT_W = $clog2(MAX_RAW_BYTES + 1);
	localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_RAW_BYTES);

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_SEQLEN = 4'd1,
		PH_TAG1   = 4'd2,
		PH_LEN1   = 4'd3,
		PH_SKIP1  = 4'd4,
		PH_COPY1  = 4'd5,
		PH_TAG2   = 4'd6,
		PH_LEN2   = 4'd7,
		PH_SKIP2  = 4'd8,
		PH_COPY2  = 4'd9,
		PH_DONE   = 4'd10
	} phase_t;

	phase_t           phase_q, phase_d;
	logic [7:0]       remaining_q, remaining_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic             second;
	logic [7:0]       even_len;
	logic [7:0]       rem_dec;
	logic [CNT_W-1:0] cnt_inc;

	assign second   = (phase_q == PH_LEN2) || (phase_q == PH_SKIP2) || (phase_q == PH_COPY2);
	assign even_len = {data_byte[7:1], 1'b0};
	assign rem_dec  = remaining_q - 8'd1;
	assign cnt_inc  = count_q + CNT_W'(1);

	always_comb begin
		phase_d     = phase_q;
		remaining_d = remaining_q;
		count_d     = count_q;
		res_valid   = 1'b0;
		res         = '0;
		if (start_req) begin
			remaining_d = '0;
			count_d     = '0;
			if (data_byte != SEQ_TAG) begin
				phase_d    = PH_DONE;
				res_valid  = 1'b1;
				res.done_res = 1'b1;
				res.status = ST_SEQTAG;
			end else begin
				phase_d = PH_SEQLEN;
			end
		end else begin
			case (phase_q)
				PH_SEQLEN: begin
					if (total_length < 8'd2 || data_byte != total_length - 8'd2) begin
						phase_d      = PH_DONE;
						res_valid    = 1'b1;
						res.done_res = 1'b1;
						res.status   = ST_LEN;
						res.raw_length = 8'(count_q);
					end else begin
						phase_d = PH_TAG1;
					end
				end
				PH_TAG1, PH_TAG2: begin
					if (data_byte != INT_TAG) begin
						phase_d      = PH_DONE;
						res_valid    = 1'b1;
						res.done_res = 1'b1;
						res.status   = ST_INTTAG;
						res.raw_length = 8'(count_q);
					end else begin
						phase_d = (phase_q == PH_TAG1) ? PH_LEN1 : PH_LEN2;
					end
				end
				PH_LEN1, PH_LEN2: begin
					remaining_d = even_len;
					if (data_byte[0]) begin
						phase_d = second ? PH_SKIP2 : PH_SKIP1;
					end else if (even_len == 8'd0) begin
						if (second) begin
							phase_d        = PH_DONE;
							res_valid      = 1'b1;
							res.done_res   = 1'b1;
							res.raw_length = 8'(count_q);
						end else begin
							phase_d = PH_TAG2;
						end
					end else begin
						phase_d = second ? PH_COPY2 : PH_COPY1;
					end
				end
				PH_SKIP1, PH_SKIP2: begin
					if (remaining_q == 8'd0) begin
						if (second) begin
							phase_d        = PH_DONE;
							res_valid      = 1'b1;
							res.done_res   = 1'b1;
							res.raw_length = 8'(count_q);
						end else begin
							phase_d = PH_TAG2;
						end
					end else begin
						phase_d = second ? PH_COPY2 : PH_COPY1;
					end
				end
				PH_COPY1, PH_COPY2: begin
					res_valid = 1'b1;
					if (count_q == MaxCnt) begin
						// buffer full: drop the byte and close with overflow
						phase_d        = PH_DONE;
						res.done_res   = 1'b1;
						res.status     = ST_OVER;
						res.raw_length = 8'(count_q);
					end else begin
						count_d        = cnt_inc;
						remaining_d    = rem_dec;
						res.out_byte   = data_byte;
						res.byte_valid = 1'b1;
						if (rem_dec == 8'd0) begin
							if (second) begin
								phase_d        = PH_DONE;
								res.done_res   = 1'b1;
								res.raw_length = 8'(cnt_inc);
							end else begin
								phase_d = PH_TAG2;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			remaining_q <= '0;
			count_q     <= '0;
		end else if (take) begin
			phase_q     <= phase_d;
			remaining_q <= remaining_d;
			count_q     <= count_d;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MaxCnt)
		else $error("emitted count beyond buffer size");

	a_remaining_even: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SKIP1 || phase_q == PH_SKIP2) |-> remaining_q[0] == 1'b0)
		else $error("odd remaining count at sign pad");

	a_copy_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_COPY1 || phase_q == PH_COPY2) |-> remaining_q != 8'd0)
		else $error("copy phase with nothing left to copy");

endmodule

// File: rtl/der_ecdsa_signature_unpacker_top.sv
// ----------------------------------------------------------------------------
// DER ECDSA signature unpacker
// Streams a DER SEQUENCE { INTEGER r, INTEGER s } one byte per beat on sig and
// returns the raw r and s content bytes, in r-then-s order, on raw. The
// sequence tag, the sequence length (total_length - 2, sampled with the second
// byte) and both integer tags are checked; an odd integer length drops its
// first content byte as the sign pad. Each signature ends in one beat with
// done_res set, carrying status and the count of bytes sent; on a nonzero
// status the consumer discards the bytes of that signature. The last s byte
// and the ok status share one beat. More than MAX_RAW_BYTES content bytes end
// the signature with an overflow status. start_req restarts at any beat,
// abandoning a signature in progress; bytes after the final beat are dropped
// until the next start. sig accepts a beat in every cycle in which the
// single result register on raw is empty or is being drained, and a result
// appears on raw in the cycle after its byte.
// ----------------------------------------------------------------------------
module der_ecdsa_signature_unpacker_top #(
	parameter int MAX_RAW_BYTES = 128
) (
	input  logic           clk,
	input  logic           arst_n,
	der_unpk_in_if.sink    sig,
	der_unpk_out_if.source raw
);
	import der_unpk_pkg::*;

	logic take;
	logic res_valid;
	res_t res;
	logic valid_q;
	res_t res_q;

	// Accept while the result register is free or being taken this cycle.
	assign sig.ready = !valid_q || raw.ready;
	assign take      = sig.valid && sig.ready;

	der_unpk_parser #(
		.MAX_RAW_BYTES(MAX_RAW_BYTES)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.data_byte   (sig.data_byte),
		.start_req   (sig.start_req),
		.total_length(sig.total_length),
		.res_valid   (res_valid),
		.res         (res)
	);

	// Hold the result until the consumer takes it; advance on a new result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take && res_valid) begin
			valid_q <= 1'b1;
		end else if (raw.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res_valid) begin
			res_q <= res;
		end
	end

	assign raw.valid      = valid_q;
	assign raw.out_byte   = res_q.out_byte;
	assign raw.byte_valid = res_q.byte_valid;
	assign raw.done_res   = res_q.done_res;
	assign raw.status     = res_q.status;
	assign raw.raw_length = res_q.raw_length;

	// Every result beat carries a byte, a final status, or both.
	a_beat_has_content: assert property (@(posedge clk) disable iff (!arst_n)
		raw.valid |-> (raw.byte_valid || raw.done_res))
		else $error("empty result beat");

	// A beat without a byte shows a zero byte; a beat without done shows no status.
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		raw.valid |-> ((raw.byte_valid || raw.out_byte == 8'd0) &&
			(raw.done_res || (raw.status == ST_OK && raw.raw_length == 8'd0))))
		else $error("stray field in result beat");

	// A result held back by the consumer blocks the input side.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(raw.valid && !raw.ready) |-> !sig.ready)
		else $error("input accepted over a pending result");

endmodule
